[hw/rtl/rrc_matched_filter_demodulator_macros.svh]
// Assertion macros shared by the RRC matched filter RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef RRC_MATCHED_FILTER_DEMODULATOR_MACROS_SVH
`define RRC_MATCHED_FILTER_DEMODULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rmfd_pkg.sv]
// Package for the RRC matched filter: types, fixed widths and the
// build-time coefficient generator. No dependencies.
`default_nettype none

package rmfd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int INDEX_W   = 2;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = SAMPLE_W / DIGIT_W;
    localparam int DIG_CNT_W = 2;

    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [63:0] Q30_PI       = 64'd3373259426;
    localparam logic [63:0] Q30_HALFPI   = 64'd1686629713;
    localparam logic [63:0] Q30_INVSQRT2 = 64'd759250125;

    localparam logic [63:0] SIN_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    localparam logic [63:0] COS_DIV [7] =
        '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // sequencer -> digit multiplier
    typedef struct packed {
        logic run;
        logic first_dig;
        logic last_dig;
        logic first_tap;
        logic last_tap;
        logic zero_base;
    } t_mac_ctl;

    // digit multiplier -> accumulator queue, aligned with a finished product
    typedef struct packed {
        logic valid;
        logic first_tap;
        logic last_tap;
        logic zero_base;
    } t_prod_ctl;

    // Restoring long division, elaboration only.
    function automatic logic [63:0] rmfd_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Divide, rounding to nearest with ties away from zero.
    function automatic longint rmfd_rdiv(input longint n, input longint d);
        longint nn;
        longint dd;
        longint half;
        nn = n;
        dd = d;
        if (dd < 0) begin
            nn = -nn;
            dd = -dd;
        end
        half = dd >>> 1;
        if (nn >= 0) begin
            return longint'(rmfd_udiv(64'(nn + half), 64'(dd)));
        end
        return -longint'(rmfd_udiv(64'(-nn + half), 64'(dd)));
    endfunction

    // {sin, cos} in Q30 of a/d turns (angle 2*pi*a/d)
    function automatic logic [127:0] rmfd_sincos(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] p;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sub;
        longint s0;
        longint c0;
        longint s;
        longint c;
        p    = a - rmfd_udiv(a, d) * d;
        quad = rmfd_udiv(4 * p, d);
        rem  = 4 * p - quad * d;
        th   = rmfd_udiv(rem * Q30_HALFPI + (d >> 1), d);
        x2   = (th * th) >> 30;
        t    = Q30_ONE;
        for (int k = 0; k < 6; k++) begin
            sub = rmfd_udiv((x2 * t) >> 30, SIN_DIV[k]);
            t   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        end
        s0 = longint'((th * t) >> 30);
        t  = Q30_ONE;
        for (int k = 0; k < 7; k++) begin
            sub = rmfd_udiv((x2 * t) >> 30, COS_DIV[k]);
            t   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        end
        c0 = longint'(t);
        case (quad[1:0])
            2'd0: begin
                s = s0;
                c = c0;
            end
            2'd1: begin
                s = c0;
                c = -s0;
            end
            2'd2: begin
                s = -s0;
                c = -c0;
            end
            default: begin
                s = -c0;
                c = s0;
            end
        endcase
        return {64'(s), 64'(c)};
    endfunction

    // Tap at t = u/(2n) symbols, u >= 0, with f fraction bits
    function automatic longint rmfd_tap(input longint u, input longint n, input longint rm,
                                        input longint f);
        longint one_s;
        longint pi_s;
        longint isq_s;
        longint p;
        longint q;
        longint den;
        longint kp;
        longint hpi;
        longint s;
        longint c;
        longint v;
        longint e;
        longint t2;
        logic [127:0] sc;
        one_s = longint'(Q30_ONE);
        pi_s  = longint'(Q30_PI);
        isq_s = longint'(Q30_INVSQRT2);
        p     = 500 * n;
        q     = rm * u;
        den   = p * p - q * q;
        kp    = rmfd_rdiv((1000 - rm) * pi_s + 4 * rm * one_s, 1000);
        if (u == 0) begin
            return longint'(1) << f;
        end
        if (den == 0) begin
            // singular point t = 1/(4R): analytic limit
            sc  = rmfd_sincos(64'd1000, 64'(8 * rm));
            s   = longint'(sc[127:64]);
            c   = longint'(sc[63:0]);
            v   = rmfd_rdiv((pi_s + 2 * one_s) * s + (pi_s - 2 * one_s) * c, one_s);
            hpi = rmfd_rdiv(rmfd_rdiv(v * isq_s, one_s) * rm, 1000);
        end else begin
            sc  = rmfd_sincos(64'((1000 - rm) * u), 64'(4000 * n));
            s   = longint'(sc[127:64]);
            sc  = rmfd_sincos(64'((1000 + rm) * u), 64'(4000 * n));
            c   = longint'(sc[63:0]);
            e   = s + rmfd_rdiv(q * c, p);
            t2  = rmfd_rdiv(e * 2 * n, u);
            hpi = rmfd_rdiv(t2 * p * p, den);
        end
        if (hpi > (longint'(1) << 36)) begin
            hpi = longint'(1) << 36;
        end
        if (hpi < -(longint'(1) << 36)) begin
            hpi = -(longint'(1) << 36);
        end
        return rmfd_rdiv(hpi * (longint'(1) << f), kp);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rmfd_digit_mac.sv]
// Sample ring and radix-16 digit-serial multiplier for the RRC filter.
// Depends on rmfd_pkg.
`default_nettype none

module rmfd_digit_mac import rmfd_pkg::*; #(
    parameter int N      = 4,
    parameter int COEF_W = 18
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic        [INDEX_W-1:0]        i_wr_index,
    input  logic signed [SAMPLE_W-1:0]       i_wr_value,
    input  t_mac_ctl                         i_ctl,
    input  logic signed [COEF_W-1:0]         i_coef,
    output logic signed [SAMPLE_W+COEF_W-1:0] o_prod,
    output t_prod_ctl                        o_pctl
);

    localparam int RING_W = N * SAMPLE_W;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int MUL_W  = DIGIT_W + 1 + COEF_W;

    // sample 0 sits at the top; while the multiplier runs the ring turns one digit a cycle and is home
    // again after every full pass over the samples
    logic        [RING_W-1:0]  r_ring;
    logic        [RING_W-1:0]  n_ring;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  w_shifted;
    t_prod_ctl                 r_pctl;
    logic        [DIGIT_W-1:0] w_dig;
    logic signed [DIGIT_W:0]   w_sdig;
    logic signed [MUL_W-1:0]   w_mul;

    always_comb begin
        n_ring = r_ring;
        if (i_ctl.run) begin
            n_ring = {r_ring[RING_W-DIGIT_W-1:0], r_ring[RING_W-1 -: DIGIT_W]};
        end else if (i_wr_en) begin
            for (int j = 0; j < N; j++) begin
                if (32'(i_wr_index) == j) begin
                    n_ring[(N-1-j)*SAMPLE_W +: SAMPLE_W] = i_wr_value;
                end
            end
        end
    end

    // MSB-first Horner: only the leading digit carries the sign
    always_comb begin
        w_dig     = r_ring[RING_W-1 -: DIGIT_W];
        w_sdig    = {w_dig[DIGIT_W-1] & i_ctl.first_dig, w_dig};
        w_mul     = MUL_W'(w_sdig) * MUL_W'(i_coef);
        w_shifted = i_ctl.first_dig ? '0 : (r_prod <<< DIGIT_W);
        n_prod    = w_shifted + PROD_W'(w_mul);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
            r_pctl <= '0;
        end else begin
            r_ring           <= n_ring;
            r_pctl.valid     <= i_ctl.run & i_ctl.last_dig;
            r_pctl.first_tap <= i_ctl.first_tap;
            r_pctl.last_tap  <= i_ctl.last_tap;
            r_pctl.zero_base <= i_ctl.zero_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;
    assign o_pctl = r_pctl;

endmodule

`default_nettype wire

[hw/rtl/rmfd_sum_queue.sv]
// Accumulator queue: truncates products, sums taps and shifts saturated
// entries through the queue. Depends on rmfd_pkg.
`default_nettype none

module rmfd_sum_queue import rmfd_pkg::*; #(
    parameter int N      = 4,
    parameter int L      = 16,
    parameter int COEF_W = 18,
    parameter int FRAC   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [SAMPLE_W+COEF_W-1:0] i_prod,
    input  t_prod_ctl                         i_pctl,
    output logic signed [SUM_W-1:0]           o_oldest
);

    localparam int PROD_W  = SAMPLE_W + COEF_W;
    localparam int TRUNC_W = PROD_W - FRAC;
    localparam int MAX_W   = (SUM_W > TRUNC_W) ? SUM_W : TRUNC_W;
    localparam int ACC_W   = MAX_W + $clog2(N) + 1;

    logic signed [SUM_W-1:0]   r_q [L];
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   w_start;
    logic signed [SUM_W-1:0]   w_base;
    logic signed [SUM_W-1:0]   w_sat;
    logic signed [TRUNC_W-1:0] w_floor;
    logic                      w_cin;
    logic                      w_ovf;

    generate
        if (L > 1) begin : g_base
            assign w_base = i_pctl.zero_base ? '0 : r_q[L-2];
        end else begin : g_base_zero
            assign w_base = '0;
        end
    endgenerate

    // toward-zero truncation: floor plus one for a negative product with
    // a non-zero fraction
    always_comb begin
        w_floor = i_prod[PROD_W-1:FRAC];
        w_cin   = i_prod[PROD_W-1] & (|i_prod[FRAC-1:0]);
        w_start = i_pctl.first_tap ? ACC_W'(w_base) : r_acc;
        n_acc   = w_start + ACC_W'(w_floor) + $signed({{(ACC_W-1){1'b0}}, w_cin});
        w_ovf   = (n_acc[ACC_W-1:SUM_W-1] != '0) && (n_acc[ACC_W-1:SUM_W-1] != '1);
        if (w_ovf) begin
            w_sat = {n_acc[ACC_W-1], {(SUM_W-1){~n_acc[ACC_W-1]}}};
        end else begin
            w_sat = n_acc[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < L; m++) begin
                r_q[m] <= '0;
            end
        end else if (i_pctl.valid && i_pctl.last_tap) begin
            r_q[0] <= w_sat;
            for (int m = 1; m < L; m++) begin
                r_q[m] <= r_q[m-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_oldest = r_q[L-1];

endmodule

`default_nettype wire

[hw/rtl/rrc_matched_filter_demodulator.sv]
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// input    | i_valid / o_ready   | i_sample_index, i_sample_value, i_end_of_symbol
// output   | o_valid / i_ready   | o_filter_sum
//
// A beat without end of symbol is written to the sample store; ready stays high.
// After an end-of-symbol beat, ready stays low until its sum is loaded;
// one radix-16 digit multiplier, four digits a product.
// The sum is held in an output register; a new sum waits only if the
// previous one has not been taken. Synchronous active-low reset clears the
// sample store and the queue at once.
// Top level of the RRC matched filter. Depends on rmfd_pkg, rmfd_digit_mac,
// rmfd_sum_queue and the assertion macro header.
`default_nettype none
`include "rrc_matched_filter_demodulator_macros.svh"

module rrc_matched_filter_demodulator import rmfd_pkg::*; #(
    parameter int SAMPLES_PER_SYMBOL = 4,
    parameter int SPAN_SYMBOLS       = 16,
    parameter int ROLLOFF_MILLI      = 400,
    parameter int COEF_FRAC_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic        [INDEX_W-1:0]  i_sample_index,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_end_of_symbol,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SUM_W-1:0]    o_filter_sum
);

    localparam int N         = SAMPLES_PER_SYMBOL;
    localparam int L         = SPAN_SYMBOLS;
    localparam int COEF_W    = COEF_FRAC_BITS + 2;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ROM_DEPTH = N * L;
    localparam int AW        = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
    localparam int JW        = (N > 1) ? $clog2(N) : 1;
    localparam int KW        = (L > 1) ? $clog2(L) : 1;

    t_state                  r_state;
    t_state                  n_state;
    logic [DIG_CNT_W-1:0]    r_dig;
    logic [DIG_CNT_W-1:0]    n_dig;
    logic [JW-1:0]           r_tap;
    logic [JW-1:0]           n_tap;
    logic [KW-1:0]           r_ent;
    logic [KW-1:0]           n_ent;
    logic [AW-1:0]           r_addr;
    logic [AW-1:0]           n_addr;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic                    w_load;
    logic                    w_in_beat;
    t_mac_ctl                w_ctl;
    t_prod_ctl               w_pctl;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0] w_oldest;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [COEF_W-1:0] w_coef_tab [ROM_DEPTH];

    // coefficient ROM, entry i*N + j, built at elaboration
    generate
        for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
            localparam int TI = g / SAMPLES_PER_SYMBOL;
            localparam int TJ = g % SAMPLES_PER_SYMBOL;
            localparam int TU = 2 * N * TI - L * N + 2 * TJ;
            localparam longint TAP = rmfd_tap(longint'((TU < 0) ? -TU : TU), longint'(N),
                                              longint'(ROLLOFF_MILLI),
                                              longint'(COEF_FRAC_BITS));
            assign w_coef_tab[g] = COEF_W'(TAP);
        end
    endgenerate

    assign w_coef    = w_coef_tab[r_addr];
    assign w_in_beat = i_valid & o_ready;

    // entries run from the oldest down to entry 0; each shift of the queue
    // brings the next base value to the tap below the oldest
    always_comb begin
        n_state         = r_state;
        n_dig           = r_dig;
        n_tap           = r_tap;
        n_ent           = r_ent;
        n_addr          = r_addr;
        w_load          = 1'b0;
        w_ctl.run       = (r_state == ST_MAC);
        w_ctl.first_dig = (r_dig == '0);
        w_ctl.last_dig  = (r_dig == DIG_CNT_W'(DIGITS - 1));
        w_ctl.first_tap = (r_tap == '0);
        w_ctl.last_tap  = (r_tap == JW'(N - 1));
        w_ctl.zero_base = (r_ent == KW'(L - 1));
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_end_of_symbol) begin
                    n_state = ST_MAC;
                    n_dig   = '0;
                    n_tap   = '0;
                    n_ent   = '0;
                    n_addr  = AW'((L - 1) * N);
                end
            end
            ST_MAC: begin
                if (w_ctl.last_dig) begin
                    n_dig = '0;
                    if (w_ctl.last_tap) begin
                        n_tap  = '0;
                        n_addr = r_addr - AW'(2 * N - 1);
                        if (w_ctl.zero_base) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_ent = r_ent + 1'b1;
                        end
                    end else begin
                        n_tap  = r_tap + 1'b1;
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = w_load | (r_out_valid & ~i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dig       <= '0;
            r_tap       <= '0;
            r_ent       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dig       <= n_dig;
            r_tap       <= n_tap;
            r_ent       <= n_ent;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sum <= w_oldest;
        end
    end

    rmfd_digit_mac #(
        .N      (N),
        .COEF_W (COEF_W)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_in_beat),
        .i_wr_index (i_sample_index),
        .i_wr_value (i_sample_value),
        .i_ctl      (w_ctl),
        .i_coef     (w_coef),
        .o_prod     (w_prod),
        .o_pctl     (w_pctl)
    );

    rmfd_sum_queue #(
        .N      (N),
        .L      (L),
        .COEF_W (COEF_W),
        .FRAC   (COEF_FRAC_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_prod   (w_prod),
        .i_pctl   (w_pctl),
        .o_oldest (w_oldest)
    );

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_filter_sum = r_sum;

    `RMFD_ASSERT_NEXT(a_eos_starts_mac, i_clk, i_rst_n,
        w_in_beat && i_end_of_symbol, r_state == ST_MAC, "end-of-symbol beat did not start MAC")
    `RMFD_ASSERT_NOW(a_drain_has_last_product, i_clk, i_rst_n,
        r_state == ST_DRAIN, w_pctl.valid && w_pctl.last_tap && w_pctl.zero_base,
        "drain cycle without the final product")
    `RMFD_ASSERT_NOW(a_valid_rises_from_out, i_clk, i_rst_n,
        $rose(o_valid), $past(r_state == ST_OUT), "sum presented outside output state")
    `RMFD_ASSERT_NEXT(a_out_loads, i_clk, i_rst_n,
        r_state == ST_OUT && (!o_valid || i_ready), r_state == ST_IDLE && o_valid,
        "free output register not loaded")

endmodule

`default_nettype wire

[sim/tb_rrc_matched_filter_demodulator.sv]
// Self-checking bench for the RRC matched filter demodulator: directed table, then random
// symbols under four idle/stall regimes, checked against a bit-exact tap ROM and queue model.
// Depends on rmfd_pkg and rrc_matched_filter_demodulator.
`timescale 1ns / 1ps

module tb_rrc_matched_filter_demodulator;
    import rmfd_pkg::*;

    localparam int N_SAMP      = 4;
    localparam int SPAN        = 16;
    localparam int ROLL        = 400;
    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 300;
    localparam int DIR_ROWS    = 21;
    localparam int PHASE_BEATS = 232;

    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint INVSQRT2_Q30 = 64'sd759250125;
    localparam logic [63:0] ONE_U    = 64'd1073741824;
    localparam logic [63:0] HALFPI_U = 64'd1686629713;
    localparam longint FRAC_SCALE   = longint'(1) << FRAC;
    localparam longint HPI_CLAMP    = longint'(1) << 36;
    localparam longint SUM_HI       = 64'sd8388607;
    localparam longint SUM_LO       = -64'sd8388608;

    typedef struct {
        logic [INDEX_W-1:0]         idx;
        logic signed [SAMPLE_W-1:0] val;
        logic                       eos;
        bit                         typed;
        logic signed [SUM_W-1:0]    sum;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [INDEX_W-1:0]         i_sample_index;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic                       i_end_of_symbol;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SUM_W-1:0]    o_filter_sum;

    longint                     tap_rom [SPAN][N_SAMP];
    logic signed [SAMPLE_W-1:0] sample_store [N_SAMP];
    logic signed [SUM_W-1:0]    sum_line [SPAN];
    logic signed [SUM_W-1:0]    sum_expect_q [$];
    int                         mismatches = 0;
    int                         idle_pct;
    int                         stall_pct;

    rrc_matched_filter_demodulator #(
        .SAMPLES_PER_SYMBOL (N_SAMP),
        .SPAN_SYMBOLS       (SPAN),
        .ROLLOFF_MILLI      (ROLL),
        .COEF_FRAC_BITS     (FRAC)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_index  (i_sample_index),
        .i_sample_value  (i_sample_value),
        .i_end_of_symbol (i_end_of_symbol),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_filter_sum    (o_filter_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // nearest, ties away from zero
    function automatic longint round_div(input longint n, input longint d);
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n >= 0) begin
            return (n + d / 2) / d;
        end
        return -((-n + d / 2) / d);
    endfunction

    // Q30 sin/cos of 2*pi*a/d; quadrant reduced exactly, truncating Horner steps
    function automatic void q30_sincos(input logic [63:0] a, input logic [63:0] d,
                                       output longint s, output longint c);
        logic [63:0] ph;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sub;
        logic [63:0] dv;
        longint      s0;
        longint      c0;
        int          k;
        ph   = a % d;
        quad = (4 * ph) / d;
        rem  = (4 * ph) % d;
        th   = (rem * HALFPI_U + d / 2) / d;
        x2   = (th * th) >> 30;
        t    = ONE_U;
        for (k = 0; k < 6; k++) begin
            dv  = 64'((13 - 2 * k) * (12 - 2 * k));
            sub = ((x2 * t) >> 30) / dv;
            t   = (sub >= ONE_U) ? 64'd0 : ONE_U - sub;
        end
        s0 = longint'((th * t) >> 30);
        t  = ONE_U;
        for (k = 0; k < 7; k++) begin
            dv  = 64'((14 - 2 * k) * (13 - 2 * k));
            sub = ((x2 * t) >> 30) / dv;
            t   = (sub >= ONE_U) ? 64'd0 : ONE_U - sub;
        end
        c0 = longint'(t);
        case (quad[1:0])
            2'd0: begin
                s = s0;
                c = c0;
            end
            2'd1: begin
                s = c0;
                c = -s0;
            end
            2'd2: begin
                s = -s0;
                c = -c0;
            end
            default: begin
                s = -c0;
                c = s0;
            end
        endcase
    endfunction

    // tap at t = u/(2N) symbols, u >= 0
    function automatic longint rrc_coef(input longint u);
        longint p;
        longint q;
        longint den;
        longint kp;
        longint hpi;
        longint s;
        longint c;
        longint unused;
        longint v;
        longint e;
        longint t2;
        p   = 500 * N_SAMP;
        q   = ROLL * u;
        den = p * p - q * q;
        kp  = round_div((1000 - ROLL) * PI_Q30 + 4 * ROLL * ONE_Q30, 1000);
        if (u == 0) begin
            return FRAC_SCALE;
        end
        if (den == 0) begin
            // t = 1/(4R): analytic limit of the pulse
            q30_sincos(64'd1000, 64'(8 * ROLL), s, c);
            v   = round_div((PI_Q30 + 2 * ONE_Q30) * s + (PI_Q30 - 2 * ONE_Q30) * c, ONE_Q30);
            hpi = round_div(round_div(v * INVSQRT2_Q30, ONE_Q30) * ROLL, 1000);
        end else begin
            q30_sincos(64'((1000 - ROLL) * u), 64'(4000 * N_SAMP), s, unused);
            q30_sincos(64'((1000 + ROLL) * u), 64'(4000 * N_SAMP), unused, c);
            e   = s + round_div(q * c, p);
            t2  = round_div(e * 2 * N_SAMP, u);
            hpi = round_div(t2 * p * p, den);
        end
        if (hpi > HPI_CLAMP) begin
            hpi = HPI_CLAMP;
        end
        if (hpi < -HPI_CLAMP) begin
            hpi = -HPI_CLAMP;
        end
        return round_div(hpi * FRAC_SCALE, kp);
    endfunction

    function automatic void build_taps();
        longint u;
        int     i;
        int     j;
        for (i = 0; i < SPAN; i++) begin
            for (j = 0; j < N_SAMP; j++) begin
                u = 2 * N_SAMP * i - SPAN * N_SAMP + 2 * j;
                if (u < 0) begin
                    u = -u;
                end
                tap_rom[i][j] = rrc_coef(u);
            end
        end
    endfunction

    // store the sample; on end of symbol shift the sum line, accumulate, emit the oldest
    function automatic void filter_beat(input logic [INDEX_W-1:0] idx,
                                        input logic signed [SAMPLE_W-1:0] val,
                                        input logic eos, output bit emit,
                                        output logic signed [SUM_W-1:0] sum);
        longint acc;
        int     i;
        int     j;
        emit = 1'b0;
        sum  = '0;
        if (int'(idx) < N_SAMP) begin
            sample_store[idx] = val;
        end
        if (eos) begin
            for (i = SPAN - 1; i > 0; i--) begin
                sum_line[i] = sum_line[i - 1];
            end
            sum_line[0] = '0;
            for (i = 0; i < SPAN; i++) begin
                acc = longint'(sum_line[i]);
                for (j = 0; j < N_SAMP; j++) begin
                    acc += (longint'(sample_store[j]) * tap_rom[i][j]) / FRAC_SCALE;
                end
                if (acc > SUM_HI) begin
                    acc = SUM_HI;
                end
                if (acc < SUM_LO) begin
                    acc = SUM_LO;
                end
                sum_line[i] = SUM_W'(acc);
            end
            sum  = sum_line[SPAN - 1];
            emit = 1'b1;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return SAMPLE_W'($urandom_range(31)) - 16'sd16;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SUM_W-1:0] want,
                                   input logic signed [SUM_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[tb] %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Called just after an edge; leaves valid high until the beat is taken.
    task automatic send_beat(input logic [INDEX_W-1:0] idx, input logic signed [SAMPLE_W-1:0] val,
                             input logic eos, input bit typed,
                             input logic signed [SUM_W-1:0] typed_sum);
        bit                      emit;
        logic signed [SUM_W-1:0] sum;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample_index  <= idx;
        i_sample_value  <= val;
        i_end_of_symbol <= eos;
        do @(posedge i_clk); while (!o_ready);
        filter_beat(idx, val, eos, emit, sum);
        if (emit) begin
            sum_expect_q.push_back(typed ? typed_sum : sum);
        end
    endtask

    // result side
    initial begin
        logic signed [SUM_W-1:0] want;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (sum_expect_q.size() == 0) begin
                    report_mismatch("sum with nothing pending", 'x, o_filter_sum);
                end else begin
                    want = sum_expect_q.pop_front();
                    if (o_filter_sum !== want) begin
                        report_mismatch("filter_sum", want, o_filter_sum);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[rrc_matched_filter_demodulator] ERROR");
        $finish;
    end

    initial begin
        t_stim_row                  dir_rows [DIR_ROWS];
        logic [INDEX_W-1:0]         order [N_SAMP];
        logic [INDEX_W-1:0]         swap;
        int                         sent;
        int                         ph;
        int                         kind;
        int                         cnt;
        int                         r;
        int                         k;
        int                         idle_tab [4];
        int                         stall_tab [4];

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample_index  = '0;
        i_sample_value  = '0;
        i_end_of_symbol = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        idle_tab        = '{0, 76, 0, 16};
        stall_tab       = '{0, 0, 76, 16};
        for (k = 0; k < N_SAMP; k++) begin
            sample_store[k] = '0;
        end
        for (k = 0; k < SPAN; k++) begin
            sum_line[k] = '0;
        end
        build_taps();

        // zero store after reset gives exact zeros; then extremes, overwrite, bit patterns
        dir_rows = '{
            '{2'd0, 16'sh0000, 1'b1, 1'b1, 24'sd0},
            '{2'd3, 16'sh0000, 1'b1, 1'b1, 24'sd0},
            '{2'd0, 16'sh7fff, 1'b0, 1'b0, 24'sd0},
            '{2'd1, 16'sh7fff, 1'b0, 1'b0, 24'sd0},
            '{2'd2, 16'sh7fff, 1'b0, 1'b0, 24'sd0},
            '{2'd3, 16'sh7fff, 1'b1, 1'b0, 24'sd0},
            '{2'd0, 16'sh8000, 1'b0, 1'b0, 24'sd0},
            '{2'd1, 16'sh8000, 1'b0, 1'b0, 24'sd0},
            '{2'd2, 16'sh8000, 1'b0, 1'b0, 24'sd0},
            '{2'd3, 16'sh8000, 1'b1, 1'b0, 24'sd0},
            '{2'd1, 16'sh7fff, 1'b0, 1'b0, 24'sd0},
            '{2'd1, 16'sh8000, 1'b1, 1'b0, 24'sd0},
            '{2'd0, 16'sh5555, 1'b0, 1'b0, 24'sd0},
            '{2'd1, 16'shaaaa, 1'b0, 1'b0, 24'sd0},
            '{2'd2, 16'sh00ff, 1'b0, 1'b0, 24'sd0},
            '{2'd3, 16'shff00, 1'b1, 1'b0, 24'sd0},
            '{2'd2, 16'shffff, 1'b1, 1'b0, 24'sd0},
            '{2'd0, 16'sh0000, 1'b0, 1'b0, 24'sd0},
            '{2'd1, 16'sh0000, 1'b0, 1'b0, 24'sd0},
            '{2'd2, 16'sh0000, 1'b0, 1'b0, 24'sd0},
            '{2'd3, 16'sh0000, 1'b1, 1'b0, 24'sd0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            send_beat(dir_rows[r].idx, dir_rows[r].val, dir_rows[r].eos, dir_rows[r].typed,
                      dir_rows[r].sum);
        end

        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            sent      = 0;
            while (sent < PHASE_BEATS) begin
                kind = $urandom_range(99);
                if (kind < 75) begin
                    // whole symbol, slots in shuffled order, end flag on the last beat
                    for (k = 0; k < N_SAMP; k++) begin
                        order[k] = INDEX_W'(k);
                    end
                    for (k = N_SAMP - 1; k > 0; k--) begin
                        cnt      = $urandom_range(k);
                        swap     = order[k];
                        order[k] = order[cnt];
                        order[cnt] = swap;
                    end
                    for (k = 0; k < N_SAMP; k++) begin
                        send_beat(order[k], pick_sample(), k == N_SAMP - 1, 1'b0, '0);
                    end
                    sent += N_SAMP;
                end else if (kind < 90) begin
                    // short symbol: stale slots carry over
                    cnt = $urandom_range(1, 3);
                    for (k = 0; k < cnt; k++) begin
                        send_beat(INDEX_W'($urandom), pick_sample(), k == cnt - 1, 1'b0, '0);
                    end
                    sent += cnt;
                end else begin
                    send_beat(INDEX_W'($urandom), pick_sample(), 1'($urandom), 1'b0, '0);
                    sent++;
                end
            end
        end
        i_valid <= 1'b0;

        while (sum_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sum_expect_q.size() == 0) begin
            $display("[rrc_matched_filter_demodulator] OK");
        end else begin
            $display("[rrc_matched_filter_demodulator] ERROR");
        end
        $finish;
    end

endmodule
